[sv/bpt_pkg.sv]
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants of the byte-pair tree decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

   // number of symbols, and so entries of the node tables
   localparam int NODES = 256;

   // header type that carries three extra bytes before the length
   localparam logic [15:0] HDR_TYPE_SKIP = 16'h47fb;

   // node kinds as stored in the node-kind memory
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_ESCAPE  = 2'd1;
   localparam logic [1:0] KIND_PAIR    = 2'd2;

   // stream parse phase
   typedef enum logic [3:0] {
      PH_TYPE,
      PH_SKIP,
      PH_LEN,
      PH_ESC,
      PH_COUNT,
      PH_TRIPLE,
      PH_DATA,
      PH_AFTER_ESC,
      PH_DONE
   } phase_type;

   // expansion sequencer state
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOOK,
      SEQ_POP,
      SEQ_FLUSH,
      SEQ_EMIT
   } seq_type;

   // one result transaction
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic        end_of_stream;
      logic        decode_error;
      logic [23:0] stream_length;
   } rsp_item_type;

endpackage

`default_nettype wire

[sv/bpt_req_if.sv]
// ----------------------------------------------------------------------------
// bpt_req_if
// Input channel: one compressed stream byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_start;

   modport source (output valid, output in_byte, output stream_start, input ready);
   modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

`default_nettype wire

[sv/bpt_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpt_rsp_if
// Result channel: one decoded byte or status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        byte_valid;
   logic        last_of_run;
   logic        end_of_stream;
   logic        decode_error;
   logic [23:0] stream_length;

   modport source (output valid, output data_byte, output byte_valid,
                   output last_of_run, output end_of_stream, output decode_error,
                   output stream_length, input ready);
   modport sink   (input valid, input data_byte, input byte_valid,
                   input last_of_run, input end_of_stream, input decode_error,
                   input stream_length, output ready);
endinterface

`default_nettype wire

[sv/bpt_ram.sv]
// ----------------------------------------------------------------------------
// bpt_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/byte_pair_tree_decoder.sv]
// ----------------------------------------------------------------------------
// byte_pair_tree_decoder
// Header and table bytes are taken in the idle state; a literal or escape byte
// also passes through a node look-up, and an escaped byte through the emit state.
// A pair expansion looks up each pair node and each leaf, reads the stack after
// each leaf but the last, and closes with a flush; a full result register stalls it.
// Synchronous reset clears parse state and the node-kind valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pair_tree_decoder #(
   parameter int STACK_DEPTH   = 32,
   parameter int MAX_EXPANSION = 64
) (
   input wire logic clock,
   input wire logic reset,
   bpt_req_if.sink  req,
   bpt_rsp_if.source rsp
);

   import bpt_pkg::*;

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam int N_W    = $clog2(MAX_EXPANSION + 1);

   // parse state
   phase_type    phase_ff, phase_in;
   logic [1:0]   hcnt_ff, hcnt_in;
   logic [15:0]  htype_ff, htype_in;
   logic [23:0]  len_ff, len_in;
   logic [7:0]   entries_ff, entries_in;
   logic [1:0]   tpos_ff, tpos_in;
   logic [7:0]   node_ff, node_in;
   logic [7:0]   left_ff, left_in;

   // sequencer state
   seq_type      seq_ff, seq_in;
   logic [7:0]   cur_ff, cur_in;
   logic         root_ff, root_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [N_W-1:0]  n_ff, n_in;
   logic         err_ff, err_in;
   logic         pend_vld_ff, pend_vld_in;
   logic [7:0]   pend_byte_ff, pend_byte_in;
   logic [7:0]   emit_ff, emit_in;

   // node-kind valid bits and registered read of them
   logic [NODES-1:0] kvalid_ff;
   logic             kv_rd_ff;

   // output register
   logic         out_vld_ff;
   rsp_item_type out_ff;
   logic         push;
   rsp_item_type push_item;
   logic         out_free;

   // memory ports
   logic         kind_we, node_re, child_we, stk_we, stk_re;
   logic [7:0]   kind_wa, node_ra, child_wa;
   logic [1:0]   kind_wd, kind_rd, kind_eff;
   logic [15:0]  child_wd, child_rd;
   logic [SIDX_W-1:0] stk_wa, stk_ra;
   logic [7:0]   stk_wd, stk_rd;

   // input side
   logic         acc;
   phase_type    eff_phase;
   logic [1:0]   eff_hcnt, cnt_nx;
   logic [15:0]  eff_htype, htype_nx;
   logic [23:0]  eff_len;
   logic [SP_W:0] sp_plus2;

   assign req.ready = (seq_ff == SEQ_IDLE);
   assign acc       = req.valid && req.ready;
   assign out_free  = !out_vld_ff || rsp.ready;

   // a stream start restarts parsing with this byte
   assign eff_phase = req.stream_start ? PH_TYPE : phase_ff;
   assign eff_hcnt  = req.stream_start ? 2'd0 : hcnt_ff;
   assign eff_htype = req.stream_start ? 16'd0 : htype_ff;
   assign eff_len   = req.stream_start ? 24'd0 : len_ff;
   assign cnt_nx    = eff_hcnt + 2'd1;
   assign htype_nx  = {eff_htype[7:0], req.in_byte};

   assign kind_eff  = kv_rd_ff ? kind_rd : KIND_LITERAL;
   assign sp_plus2  = {1'b0, sp_ff} + (SP_W + 1)'(2);

   // memories: node kinds, children {left, right}, expansion stack
   bpt_ram #(.WIDTH(2), .DEPTH(NODES)) u_kind_ram (
      .clock(clock), .wr_en(kind_we), .wr_addr(kind_wa), .wr_data(kind_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(kind_rd)
   );

   bpt_ram #(.WIDTH(16), .DEPTH(NODES)) u_child_ram (
      .clock(clock), .wr_en(child_we), .wr_addr(child_wa), .wr_data(child_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(child_rd)
   );

   bpt_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   // parser and expansion sequencer
   always_comb begin
      phase_in     = phase_ff;
      hcnt_in      = hcnt_ff;
      htype_in     = htype_ff;
      len_in       = len_ff;
      entries_in   = entries_ff;
      tpos_in      = tpos_ff;
      node_in      = node_ff;
      left_in      = left_ff;
      seq_in       = seq_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      sp_in        = sp_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      pend_vld_in  = pend_vld_ff;
      pend_byte_in = pend_byte_ff;
      emit_in      = emit_ff;
      kind_we      = 1'b0;
      kind_wa      = node_ff;
      kind_wd      = KIND_PAIR;
      child_we     = 1'b0;
      child_wa     = node_ff;
      child_wd     = {left_ff, req.in_byte};
      node_re      = 1'b0;
      node_ra      = req.in_byte;
      stk_we       = 1'b0;
      stk_wa       = sp_ff[SIDX_W-1:0];
      stk_wd       = child_rd[7:0];
      stk_re       = 1'b0;
      stk_ra       = stk_wa - SIDX_W'(1);
      push         = 1'b0;
      push_item    = '{data_byte: 8'd0, byte_valid: 1'b0, last_of_run: 1'b0,
                       end_of_stream: 1'b0, decode_error: 1'b0,
                       stream_length: len_ff};

      case (seq_ff)
         SEQ_IDLE: begin
            if (acc) begin
               phase_in = eff_phase;
               hcnt_in  = eff_hcnt;
               htype_in = eff_htype;
               len_in   = eff_len;
               case (eff_phase)
                  PH_TYPE: begin
                     htype_in = htype_nx;
                     hcnt_in  = cnt_nx;
                     if (cnt_nx >= 2'd2) begin
                        hcnt_in  = 2'd0;
                        phase_in = (htype_nx == HDR_TYPE_SKIP) ? PH_SKIP : PH_LEN;
                     end
                  end
                  PH_SKIP: begin
                     hcnt_in = cnt_nx;
                     if (cnt_nx >= 2'd3) begin
                        hcnt_in  = 2'd0;
                        phase_in = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     len_in  = {eff_len[15:0], req.in_byte};
                     hcnt_in = cnt_nx;
                     if (cnt_nx >= 2'd3) begin
                        hcnt_in  = 2'd0;
                        phase_in = PH_ESC;
                     end
                  end
                  PH_ESC: begin
                     kind_we  = 1'b1;
                     kind_wa  = req.in_byte;
                     kind_wd  = KIND_ESCAPE;
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     entries_in = req.in_byte;
                     tpos_in    = 2'd0;
                     phase_in   = (req.in_byte == 8'd0) ? PH_DATA : PH_TRIPLE;
                  end
                  PH_TRIPLE: begin
                     case (tpos_ff)
                        2'd0: begin
                           node_in = req.in_byte;
                           tpos_in = 2'd1;
                        end
                        2'd1: begin
                           left_in = req.in_byte;
                           tpos_in = 2'd2;
                        end
                        default: begin
                           child_we   = 1'b1;
                           kind_we    = 1'b1;
                           tpos_in    = 2'd0;
                           entries_in = entries_ff - 8'd1;
                           if (entries_ff == 8'd1) begin
                              phase_in = PH_DATA;
                           end
                        end
                     endcase
                  end
                  PH_DATA: begin
                     node_re     = 1'b1;
                     cur_in      = req.in_byte;
                     root_in     = 1'b1;
                     sp_in       = '0;
                     n_in        = '0;
                     err_in      = 1'b0;
                     pend_vld_in = 1'b0;
                     seq_in      = SEQ_LOOK;
                  end
                  PH_AFTER_ESC: begin
                     emit_in  = req.in_byte;
                     phase_in = (req.in_byte != 8'd0) ? PH_DATA : PH_DONE;
                     seq_in   = SEQ_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // node kind and children of cur_ff are on the memory outputs
         SEQ_LOOK: begin
            if (root_ff && kind_eff == KIND_ESCAPE) begin
               phase_in = PH_AFTER_ESC;
               seq_in   = SEQ_IDLE;
            end else if (kind_eff == KIND_PAIR) begin
               if (sp_plus2 > (SP_W + 1)'(STACK_DEPTH)) begin
                  err_in = 1'b1;
                  seq_in = SEQ_FLUSH;
               end else begin
                  // push right, continue straight into left
                  stk_we  = 1'b1;
                  sp_in   = sp_ff + SP_W'(1);
                  cur_in  = child_rd[15:8];
                  node_ra = child_rd[15:8];
                  node_re = 1'b1;
                  root_in = 1'b0;
               end
            end else if (n_ff >= N_W'(MAX_EXPANSION)) begin
               err_in = 1'b1;
               seq_in = SEQ_FLUSH;
            end else if (sp_ff == '0 && !pend_vld_ff) begin
               // single leaf: it is the whole run
               if (out_free) begin
                  push                  = 1'b1;
                  push_item.data_byte   = cur_ff;
                  push_item.byte_valid  = 1'b1;
                  push_item.last_of_run = 1'b1;
                  seq_in                = SEQ_IDLE;
               end
            end else if (!pend_vld_ff || out_free) begin
               // release the previous leaf, hold this one
               if (pend_vld_ff) begin
                  push                 = 1'b1;
                  push_item.data_byte  = pend_byte_ff;
                  push_item.byte_valid = 1'b1;
               end
               pend_vld_in  = 1'b1;
               pend_byte_in = cur_ff;
               n_in         = n_ff + N_W'(1);
               if (sp_ff == '0) begin
                  seq_in = SEQ_FLUSH;
               end else begin
                  stk_re = 1'b1;
                  sp_in  = sp_ff - SP_W'(1);
                  seq_in = SEQ_POP;
               end
            end
         end

         // popped node is on the stack output
         SEQ_POP: begin
            cur_in  = stk_rd;
            node_ra = stk_rd;
            node_re = 1'b1;
            seq_in  = SEQ_LOOK;
         end

         // close the run with the held leaf or an empty error result
         SEQ_FLUSH: begin
            if (out_free) begin
               push                   = 1'b1;
               push_item.data_byte    = pend_vld_ff ? pend_byte_ff : 8'd0;
               push_item.byte_valid   = pend_vld_ff;
               push_item.last_of_run  = 1'b1;
               push_item.decode_error = err_ff;
               pend_vld_in            = 1'b0;
               err_in                 = 1'b0;
               seq_in                 = SEQ_IDLE;
            end
         end

         // byte after the escape: literal or end of stream
         SEQ_EMIT: begin
            if (out_free) begin
               push                    = 1'b1;
               push_item.data_byte     = emit_ff;
               push_item.byte_valid    = (emit_ff != 8'd0);
               push_item.end_of_stream = (emit_ff == 8'd0);
               push_item.last_of_run   = 1'b1;
               seq_in                  = SEQ_IDLE;
            end
         end

         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         hcnt_ff     <= 2'd0;
         htype_ff    <= 16'd0;
         len_ff      <= 24'd0;
         seq_ff      <= SEQ_IDLE;
         pend_vld_ff <= 1'b0;
         err_ff      <= 1'b0;
         sp_ff       <= '0;
         n_ff        <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hcnt_ff     <= hcnt_in;
         htype_ff    <= htype_in;
         len_ff      <= len_in;
         seq_ff      <= seq_in;
         pend_vld_ff <= pend_vld_in;
         err_ff      <= err_in;
         sp_ff       <= sp_in;
         n_ff        <= n_in;
         if (push) begin
            out_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // node-kind valid bits, cleared at reset and at every stream start
   always_ff @(posedge clock) begin
      if (reset || (acc && req.stream_start)) begin
         kvalid_ff <= '0;
      end else if (kind_we) begin
         kvalid_ff[kind_wa] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      entries_ff   <= entries_in;
      tpos_ff      <= tpos_in;
      node_ff      <= node_in;
      left_ff      <= left_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      pend_byte_ff <= pend_byte_in;
      emit_ff      <= emit_in;
      if (node_re) begin
         kv_rd_ff <= kvalid_ff[node_ra];
      end
      if (push) begin
         out_ff <= push_item;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.data_byte     = out_ff.data_byte;
   assign rsp.byte_valid    = out_ff.byte_valid;
   assign rsp.last_of_run   = out_ff.last_of_run;
   assign rsp.end_of_stream = out_ff.end_of_stream;
   assign rsp.decode_error  = out_ff.decode_error;
   assign rsp.stream_length = out_ff.stream_length;

`ifndef SYNTHESIS
   // a run never leaves a held leaf behind
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_IDLE) |-> !pend_vld_ff)
      else $error("held leaf left over after run");

   // the stack pointer always stays below the stack depth
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff < SP_W'(STACK_DEPTH))
      else $error("stack pointer out of range");

   // the run count never passes the run limit
   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_EXPANSION))
      else $error("run count past limit");

   // end of stream is a closing status without a data byte
   a_eos_shape: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.end_of_stream) |-> (!out_ff.byte_valid && out_ff.last_of_run))
      else $error("malformed end-of-stream result");
`endif

endmodule

`default_nettype wire

[verif/tb_byte_pair_tree_decoder.sv]
// ----------------------------------------------------------------------------
// tb_byte_pair_tree_decoder
// Self-checking bench for the byte-pair tree decoder. A directed table walks
// header forms, the length extremes, literals, escapes, end of stream, a child
// equal to the escape, a redefined escape, stack overflow and the run limit.
// Random streams follow, mostly well formed with random trees, mixed with
// noise and broken tables. Each accepted byte is decoded by a local model
// and every result transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_byte_pair_tree_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bpt_pkg::*;

   localparam int STACK_DEPTH   = 32;
   localparam int MAX_EXPANSION = 64;
   localparam int RANDOM_ITEMS  = 180;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 300;

   // one row of the directed table
   typedef struct packed {
      logic [7:0]   b;
      logic         s;
      logic         typed;
      rsp_item_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   bpt_req_if req_if ();
   bpt_rsp_if rsp_if ();

   byte_pair_tree_decoder #(
      .STACK_DEPTH   (STACK_DEPTH),
      .MAX_EXPANSION (MAX_EXPANSION)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // decoder model state
   phase_type    phase_q;
   logic [1:0]   hcount_q;
   logic [15:0]  htype_q;
   logic [23:0]  ulen_q;
   logic [7:0]   esc_q;
   logic [7:0]   pairs_left_q;
   logic [1:0]   tri_pos_q;
   logic [7:0]   tri_node_q;
   logic [1:0]   kind_mem [NODES];
   logic [7:0]   left_mem [NODES];
   logic [7:0]   right_mem [NODES];

   // results of the byte being decoded
   rsp_item_type run_bytes [MAX_EXPANSION];
   int           run_len;
   bit           run_trunc;

   rsp_item_type decoded_q [$];
   stim_row_type stim_table [$];

   int errors      = 0;
   int items_sent  = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_go     = 1'b0;
   int hold_left   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // new stream: parse state back to the type bytes, node kinds all literal
   task automatic start_stream();
      phase_q      = PH_TYPE;
      hcount_q     = 2'd0;
      htype_q      = 16'h0000;
      ulen_q       = 24'h000000;
      esc_q        = 8'h00;
      pairs_left_q = 8'h00;
      tri_pos_q    = 2'd0;
      tri_node_q   = 8'h00;
      for (int i = 0; i < NODES; i++) kind_mem[i] = KIND_LITERAL;
   endtask

   task automatic add_result(input logic [7:0] b, input logic v, input logic eos);
      rsp_item_type r;
      r.data_byte     = b;
      r.byte_valid    = v;
      r.last_of_run   = 1'b0;
      r.end_of_stream = eos;
      r.decode_error  = 1'b0;
      r.stream_length = (phase_q >= PH_ESC) ? ulen_q : 24'h000000;
      run_bytes[run_len] = r;
      run_len++;
   endtask

   // depth-first walk, left child first, truncated on stack or run limit
   task automatic expand_pair(input logic [7:0] root);
      logic [7:0] stk [STACK_DEPTH];
      logic [7:0] nd;
      int sp;
      stk[0] = root;
      sp = 1;
      while (sp > 0 && !run_trunc) begin
         sp--;
         nd = stk[sp];
         if (kind_mem[nd] == KIND_PAIR) begin
            if (sp + 2 > STACK_DEPTH) begin
               run_trunc = 1'b1;
            end else begin
               stk[sp]     = right_mem[nd];
               stk[sp + 1] = left_mem[nd];
               sp += 2;
            end
         end else if (run_len >= MAX_EXPANSION) begin
            run_trunc = 1'b1;
         end else begin
            add_result(nd, 1'b1, 1'b0);
         end
      end
      if (run_trunc && run_len == 0) add_result(8'h00, 1'b0, 1'b0);
   endtask

   // decode one accepted byte into run_bytes
   task automatic decode_step(input logic [7:0] b, input logic s);
      run_len   = 0;
      run_trunc = 1'b0;
      if (s) start_stream();
      case (phase_q)
         PH_TYPE: begin
            htype_q  = {htype_q[7:0], b};
            hcount_q = hcount_q + 2'd1;
            if (hcount_q >= 2'd2) begin
               hcount_q = 2'd0;
               phase_q  = (htype_q == HDR_TYPE_SKIP) ? PH_SKIP : PH_LEN;
            end
         end
         PH_SKIP: begin
            hcount_q = hcount_q + 2'd1;
            if (hcount_q >= 2'd3) begin
               hcount_q = 2'd0;
               phase_q  = PH_LEN;
            end
         end
         PH_LEN: begin
            ulen_q   = {ulen_q[15:0], b};
            hcount_q = hcount_q + 2'd1;
            if (hcount_q >= 2'd3) begin
               hcount_q = 2'd0;
               phase_q  = PH_ESC;
            end
         end
         PH_ESC: begin
            esc_q       = b;
            kind_mem[b] = KIND_ESCAPE;
            phase_q     = PH_COUNT;
         end
         PH_COUNT: begin
            pairs_left_q = b;
            tri_pos_q    = 2'd0;
            phase_q      = (b == 8'h00) ? PH_DATA : PH_TRIPLE;
         end
         PH_TRIPLE: begin
            if (tri_pos_q == 2'd0) begin
               tri_node_q = b;
               tri_pos_q  = 2'd1;
            end else if (tri_pos_q == 2'd1) begin
               left_mem[tri_node_q] = b;
               tri_pos_q = 2'd2;
            end else begin
               right_mem[tri_node_q] = b;
               kind_mem[tri_node_q]  = KIND_PAIR;
               tri_pos_q    = 2'd0;
               pairs_left_q = pairs_left_q - 8'd1;
               if (pairs_left_q == 8'h00) phase_q = PH_DATA;
            end
         end
         PH_DATA: begin
            if (kind_mem[b] == KIND_PAIR) expand_pair(b);
            else if (kind_mem[b] == KIND_ESCAPE) phase_q = PH_AFTER_ESC;
            else add_result(b, 1'b1, 1'b0);
         end
         PH_AFTER_ESC: begin
            if (b != 8'h00) begin
               add_result(b, 1'b1, 1'b0);
               phase_q = PH_DATA;
            end else begin
               add_result(8'h00, 1'b0, 1'b1);
               phase_q = PH_DONE;
            end
         end
         default: ;
      endcase
   endtask

   function automatic rsp_item_type mk_rsp(input logic [7:0] b, input logic v,
                                           input logic eos, input logic err,
                                           input logic [23:0] len);
      rsp_item_type r;
      r.data_byte     = b;
      r.byte_valid    = v;
      r.last_of_run   = 1'b1;
      r.end_of_stream = eos;
      r.decode_error  = err;
      r.stream_length = len;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] b, input logic s = 1'b0,
                          input logic typed = 1'b0, input rsp_item_type want = '0);
      stim_row_type row;
      row.b     = b;
      row.s     = s;
      row.typed = typed;
      row.want  = want;
      stim_table.push_back(row);
   endtask

   // offer one byte, wait for the handshake, then record what it decodes to
   task automatic offer_byte(input logic [7:0] b, input logic s = 1'b0,
                             input logic typed = 1'b0, input rsp_item_type want = '0);
      rsp_item_type r;
      if (req_idle_on) begin
         while ($urandom_range(0, 99) < 36) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.in_byte      <= b;
      req_if.stream_start <= s;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (!(phase_q == PH_DONE && !s)) items_sent++;
      decode_step(b, s);
      if (typed) begin
         decoded_q.push_back(want);
      end else begin
         for (int i = 0; i < run_len; i++) begin
            r = run_bytes[i];
            if (i == run_len - 1) begin
               r.last_of_run  = 1'b1;
               r.decode_error = run_trunc;
            end
            decoded_q.push_back(r);
         end
      end
   endtask

   // stream with random header, random tree and random data, mostly well formed
   task automatic random_stream();
      logic [7:0]  pool [6];
      logic [7:0]  esc;
      logic [7:0]  child;
      logic [15:0] htype;
      logic [23:0] slen;
      int ntrip, nsent, k, sel;
      esc = 8'($urandom);
      for (int i = 0; i < 6; i++) pool[i] = 8'($urandom);
      if ($urandom_range(0, 7) == 0) pool[0] = esc;
      htype = ($urandom_range(0, 3) == 0) ? HDR_TYPE_SKIP : 16'($urandom);
      offer_byte(htype[15:8], 1'b1);
      offer_byte(htype[7:0]);
      if (htype == HDR_TYPE_SKIP) repeat (3) offer_byte(8'($urandom));
      sel = $urandom_range(0, 5);
      slen = (sel == 0) ? 24'h000000 : (sel == 1) ? 24'hffffff : 24'($urandom);
      offer_byte(slen[23:16]);
      offer_byte(slen[15:8]);
      offer_byte(slen[7:0]);
      offer_byte(esc);
      ntrip = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      // now and then the table is cut short
      nsent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ntrip) : ntrip;
      offer_byte(8'(ntrip));
      for (int t = 0; t < nsent; t++) begin
         k = $urandom_range(0, 5);
         offer_byte(pool[k]);
         for (int c = 0; c < 2; c++) begin
            sel = $urandom_range(0, 99);
            // deeper pool entries keep most trees acyclic
            if (sel < 40 && k < 5) child = pool[$urandom_range(k + 1, 5)];
            else if (sel < 46) child = pool[$urandom_range(0, 5)];
            else if (sel < 60) child = esc;
            else child = 8'($urandom);
            offer_byte(child);
         end
      end
      repeat ($urandom_range(4, 16)) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            offer_byte(pool[$urandom_range(0, 5)]);
         end else if (sel < 60) begin
            offer_byte(esc);
            offer_byte(($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom));
         end else begin
            offer_byte(8'($urandom));
         end
      end
      if ($urandom_range(0, 1) == 0) begin
         offer_byte(esc);
         offer_byte(8'h00);
         if ($urandom_range(0, 3) == 0) repeat (2) offer_byte(8'($urandom));
      end
   endtask

   // result side: check each transaction, then pick the next ready
   initial begin
      rsp_item_type got;
      rsp_item_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.data_byte     = rsp_if.data_byte;
            got.byte_valid    = rsp_if.byte_valid;
            got.last_of_run   = rsp_if.last_of_run;
            got.end_of_stream = rsp_if.end_of_stream;
            got.decode_error  = rsp_if.decode_error;
            got.stream_length = rsp_if.stream_length;
            if (decoded_q.size() == 0) begin
               $error("unexpected result transaction, data_byte %0h", got.data_byte);
               errors++;
            end else begin
               want = decoded_q.pop_front();
               if (got.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, actual %0h", want.data_byte,
                         got.data_byte);
                  errors++;
               end
               if (got.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, actual %0b", want.byte_valid,
                         got.byte_valid);
                  errors++;
               end
               if (got.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                         got.last_of_run);
                  errors++;
               end
               if (got.end_of_stream !== want.end_of_stream) begin
                  $error("end_of_stream: expected %0b, actual %0b", want.end_of_stream,
                         got.end_of_stream);
                  errors++;
               end
               if (got.decode_error !== want.decode_error) begin
                  $error("decode_error: expected %0b, actual %0b", want.decode_error,
                         got.decode_error);
                  errors++;
               end
               if (got.stream_length !== want.stream_length) begin
                  $error("stream_length: expected %0h, actual %0h", want.stream_length,
                         got.stream_length);
                  errors++;
               end
            end
         end
         // long hold-off so the decoder fills up and stalls its input
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 36);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      bit second_hold;
      second_hold = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.in_byte      <= 8'h00;
      req_if.stream_start <= 1'b0;
      start_stream();

      // first stream without a start mark: skip header, maximum length
      add_row(8'h47);
      add_row(8'hfb);
      add_row(8'h00);
      add_row(8'hff);
      add_row(8'h5a);
      add_row(8'hff);
      add_row(8'hff);
      add_row(8'hff);
      add_row(8'h80);
      add_row(8'h03);
      // right child is the escape byte
      add_row(8'h41);
      add_row(8'h42);
      add_row(8'h80);
      // self loop with a literal on the left hits the run limit
      add_row(8'h10);
      add_row(8'h20);
      add_row(8'h10);
      // pair of itself on both sides overflows the stack
      add_row(8'h11);
      add_row(8'h11);
      add_row(8'h11);
      add_row(8'h00, 1'b0, 1'b1, mk_rsp(8'h00, 1'b1, 1'b0, 1'b0, 24'hffffff));
      add_row(8'hff, 1'b0, 1'b1, mk_rsp(8'hff, 1'b1, 1'b0, 1'b0, 24'hffffff));
      add_row(8'h41);
      add_row(8'h10);
      add_row(8'h11, 1'b0, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0, 1'b1, 24'hffffff));
      add_row(8'h80);
      add_row(8'h41, 1'b0, 1'b1, mk_rsp(8'h41, 1'b1, 1'b0, 1'b0, 24'hffffff));
      add_row(8'h80);
      add_row(8'h00, 1'b0, 1'b1, mk_rsp(8'h00, 1'b0, 1'b1, 1'b0, 24'hffffff));
      add_row(8'h55);
      // second stream: plain header, zero length, escape redefined as a pair
      add_row(8'h00, 1'b1);
      add_row(8'h00);
      add_row(8'h00);
      add_row(8'h00);
      add_row(8'h00);
      add_row(8'h05);
      add_row(8'h01);
      add_row(8'h05);
      add_row(8'h06);
      add_row(8'h07);
      add_row(8'h05);
      add_row(8'hf0, 1'b0, 1'b1, mk_rsp(8'hf0, 1'b1, 1'b0, 1'b0, 24'h000000));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         offer_byte(stim_table[i].b, stim_table[i].s, stim_table[i].typed,
                    stim_table[i].want);

      // random part
      items_sent = 0;
      hold_go    = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         req_idle_on = !(items_sent >= 70 && items_sent < 120);
         rsp_idle_on = req_idle_on;
         if (items_sent >= 140 && !second_hold) begin
            second_hold = 1'b1;
            hold_go     = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise, with the odd stray start mark
            repeat ($urandom_range(1, 6))
               offer_byte(8'($urandom), ($urandom_range(0, 7) == 0));
         end else begin
            random_stream();
         end
      end
      req_if.valid <= 1'b0;

      // drain
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
sv/bpt_pkg.sv
sv/bpt_req_if.sv
sv/bpt_rsp_if.sv
sv/bpt_ram.sv
sv/byte_pair_tree_decoder.sv
verif/tb_byte_pair_tree_decoder.sv
